### hdl/fat12_cluster_table_allocator_top_defines.svh
// assertion macros for the fat12 table allocator
`ifndef FAT12_CLUSTER_TABLE_ALLOCATOR_TOP_DEFINES_SVH
`define FAT12_CLUSTER_TABLE_ALLOCATOR_TOP_DEFINES_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define FAT12_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FAT12_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/fat12_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fat12_pkg;

   // opcodes
   localparam logic [2:0] OP_LOAD  = 3'd0;
   localparam logic [2:0] OP_FETCH = 3'd1;
   localparam logic [2:0] OP_READ  = 3'd2;
   localparam logic [2:0] OP_WRITE = 3'd3;
   localparam logic [2:0] OP_ALLOC = 3'd4;

   // status codes
   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_RANGE   = 2'd1;
   localparam logic [1:0] STAT_NO_FREE = 2'd2;

   localparam logic [11:0] END_MARK       = 12'hfff;
   localparam logic [11:0] LIMIT_RESET    = 12'd2729;
   localparam int          RESERVED_BYTES = 3;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [11:0] byte_address;
      logic [7:0]  byte_value;
      logic [11:0] entry_index;
      logic [11:0] entry_value;
      logic [11:0] chain_length;
   } fat12_req_type;

   typedef struct packed {
      logic [11:0] read_value;
      logic [11:0] first_cluster;
      logic [1:0]  status;
   } fat12_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_FETCH_WAIT,
      ST_SCAN,
      ST_RD_HI,
      ST_RD_DONE,
      ST_CHECK,
      ST_LINK,
      ST_WR_LO,
      ST_WR_HI,
      ST_FINISH
   } fat12_state_type;

endpackage

`default_nettype wire

### hdl/fat12_cluster_table_allocator_top.sv
// FAT12 cluster table allocator. A byte store of TABLE_BYTES bytes holds a
// FAT12 table whose 12-bit entries are packed two per three bytes after three
// reserved bytes. Opcodes load or fetch one raw byte, read one entry, write
// one entry (the neighboring nibble is kept), or allocate a chain: scan from
// entry 0 for the first zero entry F, link F..F+L-1 each to its successor and
// put the end marker into F+L. Every request beat gives exactly one response
// beat. The block handles one request at a time and raises req_stall while it
// works; a finished response waits in an output register. The store is a
// single-port memory with a registered read, and one pair-address adder with
// its range compare is shared by every entry access, so an entry read fetches
// the two bytes of its pair one after the other, and an entry write then
// writes the merged pair back the same way. An allocation reads entries 0..F
// in turn and then rewrites each of F..F+L (a failed scan or an out-of-range
// chain stops early). Bytes that were never loaded read back as unknown data.
// entry_limit resets to 2729 and is written through the csr port only while
// the block is idle.
`timescale 1ns / 1ps
`default_nettype none

`include "fat12_cluster_table_allocator_top_defines.svh"

module fat12_cluster_table_allocator_top
   import fat12_pkg::*;
#(
   parameter int TABLE_BYTES = 4096
) (
   input  wire logic          clock,
   input  wire logic          reset,
   // request channel
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire fat12_req_type req_data,
   // response channel
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output fat12_rsp_type      rsp_data,
   // entry_limit write channel
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire logic [11:0]   csr_data
);

   // memory index width and width of the pair-address arithmetic
   localparam int AW = $clog2(TABLE_BYTES);
   localparam int PW = (AW + 1 > 15) ? AW + 1 : 15;
   localparam logic [PW-1:0] STORE_SIZE = PW'(TABLE_BYTES);

   // byte store
   logic [7:0]    mem [TABLE_BYTES];
   logic [AW-1:0] mem_addr;
   logic          mem_we;
   logic [7:0]    mem_wdata;
   logic [7:0]    rdata_ff;

   fat12_state_type state_ff, state_in;

   // latched request
   logic [2:0]  op_ff, op_in;
   logic [11:0] baddr_ff, baddr_in;
   logic [7:0]  bval_ff, bval_in;
   logic [11:0] eval_ff, eval_in;
   logic [11:0] clen_ff, clen_in;

   // entry engine
   logic [12:0] idx_ff, idx_in;        // entry under work
   logic [12:0] end_ff, end_in;        // F + L during allocation
   logic [11:0] first_ff, first_in;
   logic [11:0] wval_ff, wval_in;      // value for the pending entry write
   logic [7:0]  lo_ff, lo_in;
   logic [7:0]  hi_ff, hi_in;
   logic        linking_ff, linking_in;

   // result being built
   logic [11:0] rv_ff, rv_in;
   logic [11:0] fc_ff, fc_in;
   logic [1:0]  st_ff, st_in;

   logic          rsp_valid_ff, rsp_valid_in;
   fat12_rsp_type rsp_data_ff, rsp_data_in;

   logic [11:0] limit_ff, limit_in;

   // shared pair-address unit and range check
   logic [12:0]   chk_idx;
   logic [PW-1:0] half_ext;
   logic [PW-1:0] pair_addr;
   logic [PW-1:0] pair_next;
   logic          entry_ok;
   logic          byte_ok;
   logic [15:0]   word;
   logic [11:0]   entry_val;
   logic [15:0]   merged;
   logic          req_beat;
   logic          rsp_free;

   assign chk_idx   = (state_ff == ST_CHECK) ? end_ff : idx_ff;
   assign half_ext  = PW'(chk_idx[12:1]);
   assign pair_addr = (half_ext << 1) + half_ext + PW'(chk_idx[0]) + PW'(RESERVED_BYTES);
   assign pair_next = pair_addr + PW'(1);
   assign entry_ok  = (chk_idx < {1'b0, limit_ff}) && (pair_next < STORE_SIZE);
   assign byte_ok   = PW'(baddr_ff) < STORE_SIZE;

   // entry as it comes out of the two-byte read
   assign word      = {rdata_ff, lo_ff};
   assign entry_val = idx_ff[0] ? word[15:4] : word[11:0];

   // nibble merge against the word read earlier
   assign merged = idx_ff[0] ? {wval_ff, lo_ff[3:0]} : {hi_ff[7:4], wval_ff};

   assign req_stall = (state_ff != ST_IDLE);
   assign req_beat  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         linking_ff   <= 1'b0;
         limit_ff     <= LIMIT_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         linking_ff   <= linking_in;
         limit_ff     <= limit_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      baddr_ff    <= baddr_in;
      bval_ff     <= bval_in;
      eval_ff     <= eval_in;
      clen_ff     <= clen_in;
      idx_ff      <= idx_in;
      end_ff      <= end_in;
      first_ff    <= first_in;
      wval_ff     <= wval_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      rv_ff       <= rv_in;
      fc_ff       <= fc_in;
      st_ff       <= st_in;
      rsp_data_ff <= rsp_data_in;
   end

   // single-port store, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      rdata_ff <= mem[mem_addr];
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      baddr_in     = baddr_ff;
      bval_in      = bval_ff;
      eval_in      = eval_ff;
      clen_in      = clen_ff;
      idx_in       = idx_ff;
      end_in       = end_ff;
      first_in     = first_ff;
      wval_in      = wval_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      linking_in   = linking_ff;
      rv_in        = rv_ff;
      fc_in        = fc_ff;
      st_in        = st_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      limit_in     = limit_ff;
      mem_addr     = pair_addr[AW-1:0];
      mem_we       = 1'b0;
      mem_wdata    = merged[7:0];

      if (csr_valid && csr_ready) begin
         limit_in = csr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               op_in      = req_data.opcode;
               baddr_in   = req_data.byte_address;
               bval_in    = req_data.byte_value;
               eval_in    = req_data.entry_value;
               clen_in    = req_data.chain_length;
               idx_in     = {1'b0, req_data.entry_index};
               linking_in = 1'b0;
               rv_in      = '0;
               fc_in      = '0;
               st_in      = STAT_OK;
               state_in   = ST_DECODE;
            end
         end

         ST_DECODE: begin
            unique case (op_ff) inside
               OP_LOAD: begin
                  mem_addr  = PW'(baddr_ff) >= STORE_SIZE ? '0 : AW'(baddr_ff);
                  mem_wdata = bval_ff;
                  mem_we    = byte_ok;
                  if (!byte_ok) begin
                     st_in = STAT_RANGE;
                  end
                  state_in = ST_FINISH;
               end
               OP_FETCH: begin
                  mem_addr = PW'(baddr_ff) >= STORE_SIZE ? '0 : AW'(baddr_ff);
                  if (byte_ok) begin
                     state_in = ST_FETCH_WAIT;
                  end else begin
                     st_in    = STAT_RANGE;
                     state_in = ST_FINISH;
                  end
               end
               OP_READ, OP_WRITE: begin
                  // first byte of the pair goes out now
                  wval_in = eval_ff;
                  if (entry_ok) begin
                     state_in = ST_RD_HI;
                  end else begin
                     st_in    = STAT_RANGE;
                     state_in = ST_FINISH;
                  end
               end
               OP_ALLOC: begin
                  idx_in   = '0;
                  state_in = ST_SCAN;
               end
               default: begin
                  state_in = ST_FINISH;
               end
            endcase
         end

         ST_FETCH_WAIT: begin
            rv_in    = {4'h0, rdata_ff};
            state_in = ST_FINISH;
         end

         ST_SCAN: begin
            // scan ends at the first unusable entry
            if (entry_ok) begin
               state_in = ST_RD_HI;
            end else begin
               st_in    = STAT_NO_FREE;
               state_in = ST_FINISH;
            end
         end

         ST_RD_HI: begin
            mem_addr = pair_next[AW-1:0];
            lo_in    = rdata_ff;
            state_in = ST_RD_DONE;
         end

         ST_RD_DONE: begin
            hi_in = rdata_ff;
            if (op_ff == OP_READ) begin
               rv_in    = entry_val;
               state_in = ST_FINISH;
            end else if (op_ff == OP_WRITE || linking_ff) begin
               state_in = ST_WR_LO;
            end else if (entry_val == 12'h000) begin
               first_in = idx_ff[11:0];
               end_in   = idx_ff + {1'b0, clen_ff};
               state_in = ST_CHECK;
            end else begin
               idx_in   = idx_ff + 13'd1;
               state_in = ST_SCAN;
            end
         end

         ST_CHECK: begin
            // shared unit looks at entry F+L here
            if (entry_ok) begin
               linking_in = 1'b1;
               state_in   = ST_LINK;
            end else begin
               st_in    = STAT_RANGE;
               state_in = ST_FINISH;
            end
         end

         ST_LINK: begin
            wval_in  = (idx_ff == end_ff) ? END_MARK : idx_ff[11:0] + 12'd1;
            state_in = ST_RD_HI;
         end

         ST_WR_LO: begin
            mem_we    = 1'b1;
            mem_wdata = merged[7:0];
            state_in  = ST_WR_HI;
         end

         ST_WR_HI: begin
            mem_addr  = pair_next[AW-1:0];
            mem_we    = 1'b1;
            mem_wdata = merged[15:8];
            if (!linking_ff) begin
               state_in = ST_FINISH;
            end else if (idx_ff == end_ff) begin
               fc_in    = first_ff;
               state_in = ST_FINISH;
            end else begin
               idx_in   = idx_ff + 13'd1;
               state_in = ST_LINK;
            end
         end

         ST_FINISH: begin
            // hand the beat over once the output register is free
            if (rsp_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.read_value    = rv_ff;
               rsp_data_in.first_cluster = fc_ff;
               rsp_data_in.status        = st_ff;
               state_in                  = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // a request beat is followed by decode
   `FAT12_ASSERT_NEXT(a_req_decode, req_beat, state_ff == ST_DECODE,
                      "request beat not followed by decode")

   // a finishing item lands in the output register
   `FAT12_ASSERT_NEXT(a_finish_out, (state_ff == ST_FINISH) && rsp_free,
                      rsp_valid_ff && (state_ff == ST_IDLE), "response beat lost")

   // failed items report no data
   `FAT12_ASSERT_NOW(a_err_zero, rsp_valid_ff && (rsp_data_ff.status != STAT_OK),
                     (rsp_data_ff.read_value == 12'h000) && (rsp_data_ff.first_cluster == 12'h000),
                     "error response carries data")

   // chain walk never passes the end marker
   `FAT12_ASSERT_NOW(a_link_bound, linking_ff, idx_ff <= end_ff,
                     "chain walk passed its end entry")

endmodule

`default_nettype wire
